### hdl/sensor_record_decoder_crc16_core_defines.svh
// Assertion macros used by the checker file of the record decoder.
`ifndef SENSOR_RECORD_DECODER_CRC16_CORE_DEFINES_SVH
`define SENSOR_RECORD_DECODER_CRC16_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SRDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/srdc_pkg.sv
// Types, constants and the CRC byte function of the record decoder.
package srdc_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;
  localparam int unsigned CRC_SPAN    = 14;
  localparam int unsigned REC_BYTES   = 16;
  localparam int unsigned REC_BITS    = REC_BYTES * 8;

  // Payload that travels down the CRC stages.
  typedef struct packed {
    logic [REC_BITS-1:0] rec;
    logic [15:0]         crc;
  } stage_t;

  // One decoded result beat.
  typedef struct packed {
    logic              is_empty;
    logic              crc_ok;
    logic              valid_res;
    logic [31:0]       timestamp;
    logic signed [15:0] temperature;
    logic [15:0]       humidity;
    logic [31:0]       pressure;
    logic [7:0]        flag_bits;
    logic [7:0]        boot_number;
  } res_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/srdc_if.sv
// Channel interfaces: record input and decoded result output.
interface srdc_rec_if;
  logic        valid;
  logic        ready;
  logic [63:0] record_low;
  logic [63:0] record_high;

  modport source (output valid, output record_low, output record_high, input ready);
  modport sink   (input valid, input record_low, input record_high, output ready);
endinterface

interface srdc_res_if;
  logic               valid;
  logic               ready;
  logic               is_empty;
  logic               crc_ok;
  logic               valid_res;
  logic [31:0]        timestamp;
  logic signed [15:0] temperature;
  logic [15:0]        humidity;
  logic [31:0]        pressure;
  logic [7:0]         flag_bits;
  logic [7:0]         boot_number;

  modport source (output valid, output is_empty, output crc_ok, output valid_res,
                  output timestamp, output temperature, output humidity,
                  output pressure, output flag_bits, output boot_number,
                  input ready);
  modport sink   (input valid, input is_empty, input crc_ok, input valid_res,
                  input timestamp, input temperature, input humidity,
                  input pressure, input flag_bits, input boot_number,
                  output ready);
endinterface

### hdl/sensor_record_decoder_crc16_core.sv
// Top level of the stored sensor record decoder with CRC-16 check.
//
// Takes one 16-byte flash record per beat (bytes 0..7 on record_low, 8..15 on
// record_high, byte i at bits 8i+7..8i) and returns one result beat per record.
// A record of all 0xFF bytes is flagged is_empty. CRC-16/CCITT-FALSE (init
// 0xFFFF, poly 0x1021, MSB first, no final xor) runs over bytes 0..13 and is
// compared with the little-endian word in bytes 14..15 (crc_ok). valid_res is
// set when the record is not empty and the CRC matches; only then are the
// little-endian fields unpacked, otherwise they read zero. Throughput is one
// record per clock while the result is not stalled; each beat passes through
// four CRC stages (bytes 0-3, 4-7, 8-11, 12-13) and one compare/unpack stage
// that is also the output register. in_ready drops only when the result is
// stalled and every stage is full; a stall loses and repeats no beat.
module sensor_record_decoder_crc16_core (
  input  logic              clk,
  input  logic              rst_n,
  srdc_rec_if.sink          in_rec,
  srdc_res_if.source        out_res
);
  import srdc_pkg::*;

  localparam int unsigned NUM_CRC_STAGES = 4;

  // Stage handshakes; index 0 is the input side.
  logic   stg_valid [NUM_CRC_STAGES+1];
  logic   stg_ready [NUM_CRC_STAGES+1];
  stage_t stg_data  [NUM_CRC_STAGES+1];
  res_t   res;

  assign stg_valid[0]  = in_rec.valid;
  assign in_rec.ready  = stg_ready[0];
  assign stg_data[0]   = '{rec: {in_rec.record_high, in_rec.record_low}, crc: CRC_INIT};

  // Byte ranges per CRC stage.
  srdc_crc_stage #(.FIRST_BYTE(0), .NUM_BYTES(4)) u_crc0 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(stg_valid[0]), .in_ready(stg_ready[0]), .in_data(stg_data[0]),
    .out_valid(stg_valid[1]), .out_ready(stg_ready[1]), .out_data(stg_data[1])
  );

  srdc_crc_stage #(.FIRST_BYTE(4), .NUM_BYTES(4)) u_crc1 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(stg_valid[1]), .in_ready(stg_ready[1]), .in_data(stg_data[1]),
    .out_valid(stg_valid[2]), .out_ready(stg_ready[2]), .out_data(stg_data[2])
  );

  srdc_crc_stage #(.FIRST_BYTE(8), .NUM_BYTES(4)) u_crc2 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(stg_valid[2]), .in_ready(stg_ready[2]), .in_data(stg_data[2]),
    .out_valid(stg_valid[3]), .out_ready(stg_ready[3]), .out_data(stg_data[3])
  );

  // last CRC stage covers the tail of the span (bytes 12..13)
  srdc_crc_stage #(.FIRST_BYTE(12), .NUM_BYTES(CRC_SPAN - 12)) u_crc3 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(stg_valid[3]), .in_ready(stg_ready[3]), .in_data(stg_data[3]),
    .out_valid(stg_valid[4]), .out_ready(stg_ready[4]), .out_data(stg_data[4])
  );

  // Compare, erased check and unpack; its register drives the result channel.
  srdc_unpack u_unpack (
    .clk(clk), .rst_n(rst_n),
    .in_valid(stg_valid[4]), .in_ready(stg_ready[4]), .in_data(stg_data[4]),
    .out_valid(out_res.valid), .out_ready(out_res.ready), .out_data(res)
  );

  assign out_res.is_empty    = res.is_empty;
  assign out_res.crc_ok      = res.crc_ok;
  assign out_res.valid_res   = res.valid_res;
  assign out_res.timestamp   = res.timestamp;
  assign out_res.temperature = res.temperature;
  assign out_res.humidity    = res.humidity;
  assign out_res.pressure    = res.pressure;
  assign out_res.flag_bits   = res.flag_bits;
  assign out_res.boot_number = res.boot_number;

endmodule

### hdl/srdc_crc_stage.sv
// One pipeline stage that folds a range of record bytes into the running CRC.
module srdc_crc_stage #(
  parameter int unsigned FIRST_BYTE = 0,
  parameter int unsigned NUM_BYTES  = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  srdc_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output srdc_pkg::stage_t out_data
);
  import srdc_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < int'(NUM_BYTES); i++) begin
      data_nxt.crc = crc_byte(data_nxt.crc, in_data.rec[8*(int'(FIRST_BYTE)+i) +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hdl/srdc_unpack.sv
// Final stage: erased check, CRC compare and field unpack into the output register.
module srdc_unpack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srdc_pkg::stage_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output srdc_pkg::res_t   out_data
);
  import srdc_pkg::*;

  logic  valid_r;
  res_t  res_r;
  res_t  res_nxt;
  logic  empty;
  logic  ok;
  logic  good;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    empty = 1'b1;
    for (int i = 0; i < int'(REC_BYTES); i++) begin
      if (in_data.rec[8*i +: 8] != ERASED_BYTE) begin
        empty = 1'b0;
      end
    end
    // stored CRC is little-endian in bytes 14..15
    ok   = (in_data.crc == in_data.rec[8*CRC_SPAN +: 16]);
    good = !empty && ok;

    res_nxt             = '0;
    res_nxt.is_empty    = empty;
    res_nxt.crc_ok      = ok;
    res_nxt.valid_res   = good;
    if (good) begin
      res_nxt.timestamp   = in_data.rec[31:0];
      res_nxt.temperature = signed'(in_data.rec[47:32]);
      res_nxt.humidity    = in_data.rec[63:48];
      res_nxt.pressure    = in_data.rec[95:64];
      res_nxt.flag_bits   = in_data.rec[103:96];
      res_nxt.boot_number = in_data.rec[111:104];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

### hdl/srdc_checker.sv
// Port-level checker for the record decoder, bound to the top level.
`include "sensor_record_decoder_crc16_core_defines.svh"

module srdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_empty,
  input logic        crc_ok,
  input logic        valid_res,
  input logic [31:0] timestamp,
  input logic [15:0] temperature,
  input logic [15:0] humidity,
  input logic [31:0] pressure,
  input logic [7:0]  flag_bits,
  input logic [7:0]  boot_number
);

  `SRDC_ASSERT_NOW(a_valid_rule, clk, rst_n, out_valid, valid_res == (crc_ok && !is_empty), "valid_res disagrees with is_empty/crc_ok")

  `SRDC_ASSERT_NOW(a_zero_fields, clk, rst_n, out_valid && !valid_res, (timestamp == 32'd0) && (temperature == 16'd0) && (humidity == 16'd0) && (pressure == 32'd0) && (flag_bits == 8'd0) && (boot_number == 8'd0), "fields not zero on invalid record")

  `SRDC_ASSERT_NOW(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "input stalled while result register is empty")

  `SRDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(timestamp) && $stable(crc_ok), "stalled result beat changed")

endmodule

bind sensor_record_decoder_crc16_core srdc_checker u_srdc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_rec.ready),
  .out_valid(out_res.valid),
  .out_ready(out_res.ready),
  .is_empty(out_res.is_empty),
  .crc_ok(out_res.crc_ok),
  .valid_res(out_res.valid_res),
  .timestamp(out_res.timestamp),
  .temperature(out_res.temperature),
  .humidity(out_res.humidity),
  .pressure(out_res.pressure),
  .flag_bits(out_res.flag_bits),
  .boot_number(out_res.boot_number)
);

### tb/srdc_tb_pkg.sv
// Testbench-side CRC-16/CCITT-FALSE over the record bytes that the CRC covers.
package srdc_tb_pkg;
  import srdc_pkg::*;

  // Bit-serial form, MSB of each byte first; byte i sits at bits 8i+7..8i.
  function automatic logic [15:0] record_crc(input logic [127:0] rec_bits);
    logic [15:0] crc;
    logic        fb;
    crc = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      for (int k = 7; k >= 0; k--) begin
        fb  = crc[15] ^ rec_bits[8*i + k];
        crc = {crc[14:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

endpackage

### tb/record_decode_check.sv
// Watches both channels, predicts each decoded record and compares results.
module record_decode_check (
  input  logic clk,
  input  logic rst_n,
  srdc_rec_if  rec,
  srdc_res_if  res,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import srdc_pkg::*;
  import srdc_tb_pkg::*;

  res_t expected_records[$];

  function automatic res_t decode_record(input logic [127:0] rec_bits);
    res_t        r;
    logic        erased;
    logic [15:0] stored;
    r      = '0;
    erased = 1'b1;
    for (int i = 0; i < REC_BYTES; i++) begin
      if (rec_bits[8*i +: 8] != ERASED_BYTE) begin
        erased = 1'b0;
      end
    end
    stored      = rec_bits[127:112];
    r.is_empty  = erased;
    r.crc_ok    = (record_crc(rec_bits) == stored);
    r.valid_res = !erased && r.crc_ok;
    // fields stay zero unless the record is valid
    if (r.valid_res) begin
      r.timestamp   = rec_bits[31:0];
      r.temperature = rec_bits[47:32];
      r.humidity    = rec_bits[63:48];
      r.pressure    = rec_bits[95:64];
      r.flag_bits   = rec_bits[103:96];
      r.boot_number = rec_bits[111:104];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] decode mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (res.valid && res.ready) begin
        if (expected_records.size() == 0) begin
          report_mismatch("result beat with no record pending");
        end else begin
          want = expected_records.pop_front();
          check_field("is_empty",    32'(res.is_empty),    32'(want.is_empty));
          check_field("crc_ok",      32'(res.crc_ok),      32'(want.crc_ok));
          check_field("valid_res",   32'(res.valid_res),   32'(want.valid_res));
          check_field("timestamp",   res.timestamp,        want.timestamp);
          check_field("temperature", 32'(res.temperature), 32'(want.temperature));
          check_field("humidity",    32'(res.humidity),    32'(want.humidity));
          check_field("pressure",    res.pressure,         want.pressure);
          check_field("flag_bits",   32'(res.flag_bits),   32'(want.flag_bits));
          check_field("boot_number", 32'(res.boot_number), 32'(want.boot_number));
        end
      end
      if (rec.valid && rec.ready) begin
        expected_records.push_back(decode_record({rec.record_high, rec.record_low}));
      end
      pending = expected_records.size();
    end
  end

endmodule

### tb/tb_sensor_record_decoder_crc16_core.sv
// Top of the record decoder testbench: clock, reset, record stimulus, verdict.
module tb_sensor_record_decoder_crc16_core;
  timeunit 1ns;
  timeprecision 1ps;

  import srdc_pkg::*;
  import srdc_tb_pkg::*;

  localparam int RANDOM_RECORDS = 1400;
  localparam int HOLD_AT_BEAT   = 400;   // long result stall starts here
  localparam int HOLD_CYCLES    = 150;   // far longer than the 5-deep pipe
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 10;    // quiet cycles after the drain, with margin

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;        // when set, neither side idles
  bit   hold_done;
  int   beats_sent;
  int   errors;
  int   pending;

  always #5 clk = ~clk;

  srdc_rec_if rec_ch ();
  srdc_res_if res_ch ();

  sensor_record_decoder_crc16_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rec  (rec_ch),
    .out_res (res_ch)
  );

  record_decode_check decode_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .rec     (rec_ch),
    .res     (res_ch),
    .errors  (errors),
    .pending (pending)
  );

  // Bytes 14..15 get the CRC of bytes 0..13, little-endian, so the record passes.
  function automatic logic [127:0] seal(input logic [127:0] rec_bits);
    logic [127:0] r;
    r = rec_bits;
    r[127:112] = record_crc(rec_bits);
    return r;
  endfunction

  // Payload layout, little-endian from byte 0: ts, temp, hum, pressure, flags, boot.
  function automatic logic [127:0] sealed_fields(input logic [31:0] ts,
                                                 input logic [15:0] temp,
                                                 input logic [15:0] hum,
                                                 input logic [31:0] pres,
                                                 input logic [7:0]  flags,
                                                 input logic [7:0]  boot);
    return seal({16'h0000, boot, flags, pres, hum, temp, ts});
  endfunction

  function automatic logic [127:0] random_bits();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Drive one record beat at the falling edge, hold it until the block takes it,
  // then either keep valid high for the next record or idle for a while.
  // valid is touched at most once per falling edge.
  task automatic send_record(input logic [127:0] rec_bits);
    int gap;
    rec_ch.valid       <= 1'b1;
    rec_ch.record_low  <= rec_bits[63:0];
    rec_ch.record_high <= rec_bits[127:64];
    do @(posedge clk); while (!rec_ch.ready);
    beats_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      rec_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Result side: random ready with short and long stalls, one long hold-off
  // once enough beats went in so the pipe fills and in_ready drops.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm || $urandom_range(0, 99) < 60) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [127:0] directed[$];
    logic [127:0] r;
    int           kind;
    int           waited;
    rst_n              = 1'b0;
    calm               = 1'b0;
    rec_ch.valid       = 1'b0;
    rec_ch.record_low  = '0;
    rec_ch.record_high = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed records.
    // Erased record: every byte 0xFF, fields must read zero.
    directed.push_back({128{1'b1}});
    // All zero: not erased, stored CRC 0 against the real CRC.
    directed.push_back('0);
    // Zero payload with a good CRC: valid, all fields zero.
    directed.push_back(seal('0));
    // Payload bytes all 0xFF with a good CRC.
    directed.push_back(seal({16'h0000, {112{1'b1}}}));
    // Field extremes: most negative temperature, max pressure and boot id.
    directed.push_back(sealed_fields(32'h0, 16'h8000, 16'h0, 32'hFFFF_FFFF, 8'h00, 8'hFF));
    // Opposite extremes: max timestamp, most positive temperature.
    directed.push_back(sealed_fields(32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF, 32'h0, 8'hFF, 8'h00));
    // Temperature of minus one hundredth.
    directed.push_back(sealed_fields(32'h1234_5678, 16'hFFFF, 16'h1388, 32'd101325,
                                     8'hA5, 8'h3C));
    // Good record with a bit flipped in each stored CRC byte.
    directed.push_back(seal(random_bits()) ^ (128'b1 << 112));
    directed.push_back(seal(random_bits()) ^ (128'b1 << 127));
    // Good record with a payload bit flipped at each end.
    directed.push_back(seal(random_bits()) ^ 128'b1);
    directed.push_back(seal(random_bits()) ^ (128'b1 << 111));
    // Almost erased: one byte off 0xFF, first and last byte.
    directed.push_back({{120{1'b1}}, 8'hFE});
    directed.push_back({8'h7F, {120{1'b1}}});
    // Erased payload but stored CRC matches: only the CRC bytes differ from 0xFF.
    directed.push_back(seal({128{1'b1}}));
    // Plain random, good and bad.
    for (int i = 0; i < 4; i++) begin
      directed.push_back(seal(random_bits()));
      directed.push_back(random_bits());
    end
    foreach (directed[i]) begin
      send_record(directed[i]);
    end

    // Random records, mostly well formed so the unpack path stays busy.
    for (int n = 0; n < RANDOM_RECORDS; n++) begin
      calm = (n >= 900 && n < 1050);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        r = seal(random_bits());
      end else if (kind < 70) begin
        // single-bit corruption anywhere, CRC field included
        r = seal(random_bits()) ^ (128'b1 << $urandom_range(0, 127));
      end else if (kind < 82) begin
        r = random_bits();
      end else if (kind < 88) begin
        r = {128{1'b1}};
      end else if (kind < 93) begin
        r = {128{1'b1}} ^ (128'b1 << $urandom_range(0, 127));
      end else begin
        // bytes of only 0x00 and 0xFF, sealed half the time
        for (int i = 0; i < 16; i++) begin
          r[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        if ($urandom_range(0, 1) == 1) begin
          r = seal(r);
        end
      end
      send_record(r);
    end
    calm = 1'b0;
    rec_ch.valid <= 1'b0;

    // Drain: every accepted record must come back, then a few quiet cycles.
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending != 0) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (errors == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
      $finish;
    end
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
